/* rtl/core/biou_pkg.sv */
// ----------------------------------------------------------------------------
// biou_pkg: shared types and constants for box intersection over union
// Field widths, stage counts, word packing and the per-axis overlap helper.
// ----------------------------------------------------------------------------
package biou_pkg;

  // field widths
  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int AREA_BITS  = 2 * COORD_BITS;
  localparam int UNION_BITS = AREA_BITS + 1;
  localparam int REM_BITS   = AREA_BITS + 2;
  localparam int RATIO_BITS = FRAC_BITS + 1;

  // pipeline shape: overlap, multiply, union, then one divider step per stage
  localparam int DIV_STEPS  = FRAC_BITS + 1;
  localparam int NUM_STAGES = 3 + DIV_STEPS;

  // word packing
  localparam int IN_FIELDS     = 8;
  localparam int IN_DATA_BITS  = ((IN_FIELDS * COORD_BITS + 7) / 8) * 8;
  localparam int RATIO_LSB     = 4 * COORD_BITS;
  localparam int OUT_DATA_BITS = ((RATIO_LSB + RATIO_BITS + 7) / 8) * 8;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [AREA_BITS-1:0]  area_t;
  typedef logic [UNION_BITS-1:0] union_t;
  typedef logic [REM_BITS-1:0]   rem_t;
  typedef logic [RATIO_BITS-1:0] ratio_t;

  typedef struct packed {
    coord_t org;
    coord_t ext;
  } span_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t w;
    coord_t h;
  } ovl_t;

  // overlap of [s1, s1+e1) and [s2, s2+e2); zero origin and extent when apart
  function automatic span_t axis_overlap(coord_t s1, coord_t e1, coord_t s2, coord_t e2);
    logic [COORD_BITS:0] lo;
    logic [COORD_BITS:0] end1;
    logic [COORD_BITS:0] end2;
    logic [COORD_BITS:0] hi;
    logic [COORD_BITS:0] diff;
    span_t               res;
    lo   = (s1 > s2) ? {1'b0, s1} : {1'b0, s2};
    end1 = {1'b0, s1} + {1'b0, e1};
    end2 = {1'b0, s2} + {1'b0, e2};
    hi   = (end1 < end2) ? end1 : end2;
    diff = hi - lo;
    if (hi < lo) begin
      res.org = '0;
      res.ext = '0;
    end else begin
      res.org = lo[COORD_BITS-1:0];
      res.ext = diff[COORD_BITS-1:0];
    end
    return res;
  endfunction

endpackage

/* rtl/core/box_intersection_over_union.sv */
// ----------------------------------------------------------------------------
// box_intersection_over_union: IoU of two axis-aligned boxes
// Fully pipelined: overlap, areas, union, then a restoring divider with one
// quotient bit per stage. Ratio is unsigned with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                    | tuser
//  in_     | in  | a_x a_y a_w a_h b_x b_y b_w b_h         | -
//  out_    | out | ovl_x ovl_y ovl_w ovl_h ratio, 0 pad    | union_empty
//
//  Stages: overlap, multiply, union, then FRAC_BITS+1 divider steps, one per
//  stage. One word enters per cycle while in_tready is high; the divider
//  stage chain sets the depth.
//  Reset (rst_n low, synchronous) empties the pipe; no other state.
//  A stall at the output backs up only until the next empty stage, so
//  bubbles are squeezed out before in_tready drops.
// ----------------------------------------------------------------------------
module box_intersection_over_union
  import biou_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // box_a_x, box_a_y, box_a_w, box_a_h, box_b_x, box_b_y, box_b_w, box_b_h
  input  logic [IN_DATA_BITS-1:0]  in_tdata,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // overlap_x, overlap_y, overlap_w, overlap_h, ratio, zero pad
  output logic [OUT_DATA_BITS-1:0] out_tdata,
  // union_empty
  output logic [0:0]               out_tuser
);

  localparam int LAST     = NUM_STAGES - 1;
  localparam int DIV_LAST = DIV_STEPS - 1;

  logic [NUM_STAGES-1:0] valid_r;
  logic [NUM_STAGES-1:0] rdy;
  ovl_t                  ovl_r [NUM_STAGES];

  // stage 0 extras, stage 1 areas, stage 2 union
  coord_t aw_r, ah_r, bw_r, bh_r;
  area_t  inter_r, area_a_r, area_b_r;
  area_t  inter2_r;
  union_t union_r;
  logic   empty2_r;

  // divider stages
  rem_t   rem_r   [DIV_STEPS];
  ratio_t quo_r   [DIV_STEPS];
  union_t den_r   [DIV_STEPS];
  logic   empty_r [DIV_STEPS];

  // ready chain: a stage takes a word when empty or when it moves on
  always_comb begin
    rdy[LAST] = !valid_r[LAST] || out_tready;
    for (int k = LAST - 1; k >= 0; k--) begin
      rdy[k] = !valid_r[k] || rdy[k+1];
    end
  end

  assign in_tready = rdy[0];

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (rdy[0]) valid_r[0] <= in_tvalid;
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (rdy[k]) valid_r[k] <= valid_r[k-1];
      end
    end
  end

  // stage 0: per-axis overlap
  always_ff @(posedge clk) begin
    span_t sx;
    span_t sy;
    sx = axis_overlap(in_tdata[0*COORD_BITS +: COORD_BITS], in_tdata[2*COORD_BITS +: COORD_BITS],
                      in_tdata[4*COORD_BITS +: COORD_BITS], in_tdata[6*COORD_BITS +: COORD_BITS]);
    sy = axis_overlap(in_tdata[1*COORD_BITS +: COORD_BITS], in_tdata[3*COORD_BITS +: COORD_BITS],
                      in_tdata[5*COORD_BITS +: COORD_BITS], in_tdata[7*COORD_BITS +: COORD_BITS]);
    if (rdy[0] && in_tvalid) begin
      ovl_r[0].x <= sx.org;
      ovl_r[0].w <= sx.ext;
      ovl_r[0].y <= sy.org;
      ovl_r[0].h <= sy.ext;
      aw_r       <= in_tdata[2*COORD_BITS +: COORD_BITS];
      ah_r       <= in_tdata[3*COORD_BITS +: COORD_BITS];
      bw_r       <= in_tdata[6*COORD_BITS +: COORD_BITS];
      bh_r       <= in_tdata[7*COORD_BITS +: COORD_BITS];
    end
  end

  // overlap fields ride along with the word
  for (genvar k = 1; k < NUM_STAGES; k++) begin : g_ovl
    always_ff @(posedge clk) begin
      if (rdy[k] && valid_r[k-1]) ovl_r[k] <= ovl_r[k-1];
    end
  end

  // stage 1: three areas
  always_ff @(posedge clk) begin
    if (rdy[1] && valid_r[0]) begin
      inter_r  <= area_t'(ovl_r[0].w) * area_t'(ovl_r[0].h);
      area_a_r <= area_t'(aw_r) * area_t'(ah_r);
      area_b_r <= area_t'(bw_r) * area_t'(bh_r);
    end
  end

  // stage 2: union; it is zero exactly when both areas are zero
  always_ff @(posedge clk) begin
    if (rdy[2] && valid_r[1]) begin
      union_r  <= union_t'(area_a_r) + union_t'(area_b_r) - union_t'(inter_r);
      inter2_r <= inter_r;
      empty2_r <= (area_a_r == '0) && (area_b_r == '0);
    end
  end

  // stages 3..: restoring division, one quotient bit per stage
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    rem_t   r_in;
    rem_t   r_sub;
    union_t d_in;
    logic   e_in;
    ratio_t q_in;
    logic   q_bit;

    if (j == 0) begin : g_first
      assign r_in = rem_t'(inter2_r);
      assign d_in = union_r;
      assign e_in = empty2_r;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = {rem_r[j-1][REM_BITS-2:0], 1'b0};
      assign d_in = den_r[j-1];
      assign e_in = empty_r[j-1];
      assign q_in = quo_r[j-1];
    end

    assign r_sub = r_in - rem_t'(d_in);
    assign q_bit = (r_in >= rem_t'(d_in));

    always_ff @(posedge clk) begin
      if (rdy[3+j] && valid_r[2+j]) begin
        rem_r[j]   <= q_bit ? r_sub : r_in;
        quo_r[j]   <= {q_in[RATIO_BITS-2:0], q_bit};
        den_r[j]   <= d_in;
        empty_r[j] <= e_in;
      end
    end
  end

  // output word
  assign out_tvalid   = valid_r[LAST];
  assign out_tuser[0] = empty_r[DIV_LAST];
  assign out_tdata    = OUT_DATA_BITS'({(empty_r[DIV_LAST] ? ratio_t'(0) : quo_r[DIV_LAST]),
                                        ovl_r[LAST].h, ovl_r[LAST].w,
                                        ovl_r[LAST].y, ovl_r[LAST].x});

endmodule

/* rtl/core/biou_checker.sv */
// ----------------------------------------------------------------------------
// biou_checker: port-level checks for box_intersection_over_union
// Watches the stream ports only; bound to the top level below.
// ----------------------------------------------------------------------------
module biou_checker
  import biou_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_tready,
  input logic                     out_tvalid,
  input logic                     out_tready,
  input logic [OUT_DATA_BITS-1:0] out_tdata,
  input logic [0:0]               out_tuser
);

  localparam ratio_t RATIO_ONE = ratio_t'(1) << FRAC_BITS;

  logic [RATIO_BITS-1:0] ratio_f;
  assign ratio_f = out_tdata[RATIO_LSB +: RATIO_BITS];

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output word valid right after reset");

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled output word changed or dropped");

  // an empty output stage never blocks the input
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with an empty output stage");

  // empty union forces a zero ratio
  a_empty_ratio: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> ratio_f == '0)
    else $error("nonzero ratio on empty union");

  // ratio never exceeds one
  a_ratio_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ratio_f <= RATIO_ONE)
    else $error("ratio above one");

endmodule

bind box_intersection_over_union biou_checker u_biou_checker (.*);

/* sim/box_intersection_over_union_test.sv */
// ----------------------------------------------------------------------------
// box_intersection_over_union_test: self-checking bench for the IoU pipeline
// Drives box pairs on the input stream and predicts the overlap box, the
// ratio and the empty-union flag for each word. Results are checked in order
// against the prediction queue, under random idling on both sides, a long
// output hold-off that backs the pipe up, and a full-rate stretch at the end.
// ----------------------------------------------------------------------------
module box_intersection_over_union_test;
  timeunit 1ns;
  timeprecision 1ps;

  import biou_pkg::*;

  localparam int DRAIN_CYCLES  = 2 * NUM_STAGES + 10;
  localparam int HOLDOFF_CYCLES = 200;

  typedef struct {
    coord_t a_x;
    coord_t a_y;
    coord_t a_w;
    coord_t a_h;
    coord_t b_x;
    coord_t b_y;
    coord_t b_w;
    coord_t b_h;
  } box_pair_t;

  typedef struct {
    coord_t ovl_x;
    coord_t ovl_y;
    coord_t ovl_w;
    coord_t ovl_h;
    ratio_t ratio;
    logic   union_empty;
  } iou_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  // box_a_x, box_a_y, box_a_w, box_a_h, box_b_x, box_b_y, box_b_w, box_b_h
  logic [IN_DATA_BITS-1:0]  in_tdata = '0;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  // overlap_x, overlap_y, overlap_w, overlap_h, ratio, zero pad
  logic [OUT_DATA_BITS-1:0] out_tdata;
  // union_empty
  logic [0:0]               out_tuser;

  iou_result_t expected_iou[$];
  int          mismatch_count = 0;
  bit          src_idle_on = 1'b0;
  bit          sink_idle_on = 1'b0;
  bit          sink_holdoff_req = 1'b0;

  box_intersection_over_union uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // overlap of [s1, s1+e1) and [s2, s2+e2), end edges kept one bit wider
  function automatic void overlap_on_axis(input coord_t s1, input coord_t e1,
                                          input coord_t s2, input coord_t e2,
                                          output coord_t org, output coord_t ext);
    logic [COORD_BITS:0] start_edge;
    logic [COORD_BITS:0] end_edge;
    logic [COORD_BITS:0] end1;
    logic [COORD_BITS:0] end2;
    start_edge = (s1 > s2) ? {1'b0, s1} : {1'b0, s2};
    end1       = {1'b0, s1} + {1'b0, e1};
    end2       = {1'b0, s2} + {1'b0, e2};
    end_edge   = (end1 < end2) ? end1 : end2;
    if (end_edge < start_edge) begin
      org = '0;
      ext = '0;
    end else begin
      org = start_edge[COORD_BITS-1:0];
      ext = coord_t'(end_edge - start_edge);
    end
  endfunction

  // overlap box, areas, union and truncated fixed-point ratio
  function automatic iou_result_t predict_iou(input box_pair_t p);
    iou_result_t                    r;
    area_t                          area_a;
    area_t                          area_b;
    area_t                          inter;
    union_t                         uni;
    logic [AREA_BITS+FRAC_BITS-1:0] scaled;
    overlap_on_axis(p.a_x, p.a_w, p.b_x, p.b_w, r.ovl_x, r.ovl_w);
    overlap_on_axis(p.a_y, p.a_h, p.b_y, p.b_h, r.ovl_y, r.ovl_h);
    area_a = area_t'(p.a_w) * area_t'(p.a_h);
    area_b = area_t'(p.b_w) * area_t'(p.b_h);
    inter  = area_t'(r.ovl_w) * area_t'(r.ovl_h);
    uni    = union_t'(area_a) + union_t'(area_b) - union_t'(inter);
    if (uni == '0) begin
      r.union_empty = 1'b1;
      r.ratio       = '0;
    end else begin
      r.union_empty = 1'b0;
      scaled        = {inter, {FRAC_BITS{1'b0}}};
      r.ratio       = ratio_t'(scaled / uni);
    end
    return r;
  endfunction

  function automatic box_pair_t make_pair(input int ax, input int ay, input int aw,
                                          input int ah, input int bx, input int by,
                                          input int bw, input int bh);
    box_pair_t p;
    p.a_x = coord_t'(ax);
    p.a_y = coord_t'(ay);
    p.a_w = coord_t'(aw);
    p.a_h = coord_t'(ah);
    p.b_x = coord_t'(bx);
    p.b_y = coord_t'(by);
    p.b_w = coord_t'(bw);
    p.b_h = coord_t'(bh);
    return p;
  endfunction

  // mostly overlapping pairs with random content, plus noise and edge shapes
  function automatic box_pair_t random_box_pair();
    box_pair_t p;
    int        shift;
    p = make_pair($urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom);
    case ($urandom_range(0, 9))
      0, 1: begin
        // fully random fields
      end
      2, 3, 4, 5, 6: begin
        p.a_w = coord_t'($urandom_range(0, 300));
        p.a_h = coord_t'($urandom_range(0, 300));
        p.b_w = coord_t'($urandom_range(0, 300));
        p.b_h = coord_t'($urandom_range(0, 300));
        shift = $urandom_range(0, p.a_w + p.b_w);
        p.b_x = coord_t'(int'(p.a_x) + shift - int'(p.b_w));
        shift = $urandom_range(0, p.a_h + p.b_h);
        p.b_y = coord_t'(int'(p.a_y) + shift - int'(p.b_h));
      end
      7: begin
        p.a_w = coord_t'($urandom_range(32768, 65535));
        p.a_h = coord_t'($urandom_range(32768, 65535));
        p.b_w = coord_t'($urandom_range(32768, 65535));
        p.b_h = coord_t'($urandom_range(32768, 65535));
      end
      8: begin
        // touching on x, overlapping on y
        p.a_w = coord_t'($urandom_range(0, 500));
        p.b_x = p.a_x + p.a_w;
        p.b_y = p.a_y + coord_t'($urandom_range(0, 20));
      end
      default: begin
        // degenerate extents, sometimes identical boxes
        if ($urandom_range(0, 1)) begin
          p.b_x = p.a_x;
          p.b_y = p.a_y;
          p.b_w = p.a_w;
          p.b_h = p.a_h;
        end
        if ($urandom_range(0, 1)) p.a_w = '0;
        if ($urandom_range(0, 1)) p.a_h = '0;
        if ($urandom_range(0, 1)) p.b_w = '0;
        if ($urandom_range(0, 1)) p.b_h = '0;
      end
    endcase
    return p;
  endfunction

  // offer one word, hold it until accepted, then queue its prediction
  task automatic send_box_pair(input box_pair_t p);
    if (src_idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {p.b_h, p.b_w, p.b_y, p.b_x, p.a_h, p.a_w, p.a_y, p.a_x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_iou.push_back(predict_iou(p));
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, exp_val,
               act_val);
      mismatch_count++;
    end
  endtask

  // output sink: random bursts of stalls, or one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (sink_holdoff_req) begin
        sink_holdoff_req = 1'b0;
        stall_left       = HOLDOFF_CYCLES - 1;
        out_tready <= 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 9) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // result checker: every accepted word against the oldest prediction
  always @(posedge clk) begin
    iou_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_iou.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h / %b", $realtime,
                 out_tdata, out_tuser);
        mismatch_count++;
      end else begin
        exp_r = expected_iou.pop_front();
        check_field("overlap_x", 32'(exp_r.ovl_x), 32'(out_tdata[0 +: COORD_BITS]));
        check_field("overlap_y", 32'(exp_r.ovl_y),
                    32'(out_tdata[COORD_BITS +: COORD_BITS]));
        check_field("overlap_w", 32'(exp_r.ovl_w),
                    32'(out_tdata[2*COORD_BITS +: COORD_BITS]));
        check_field("overlap_h", 32'(exp_r.ovl_h),
                    32'(out_tdata[3*COORD_BITS +: COORD_BITS]));
        check_field("ratio", 32'(exp_r.ratio), 32'(out_tdata[RATIO_LSB +: RATIO_BITS]));
        check_field("pad", 32'(0), 32'(out_tdata[OUT_DATA_BITS-1:RATIO_LSB+RATIO_BITS]));
        check_field("union_empty", 32'(exp_r.union_empty), 32'(out_tuser[0]));
      end
    end
  end

  // extremes, containment, touching and separated edges, empty unions
  task automatic test_directed_shapes();
    send_box_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
    send_box_pair(make_pair(10, 20, 30, 40, 10, 20, 30, 40));
    send_box_pair(make_pair(65535, 65535, 65535, 65535, 65535, 65535, 65535, 65535));
    send_box_pair(make_pair(0, 0, 65535, 65535, 65535, 65535, 65535, 65535));
    send_box_pair(make_pair(0, 0, 65535, 65535, 1, 1, 65535, 65535));
    send_box_pair(make_pair(100, 100, 50, 50, 150, 100, 50, 50));
    send_box_pair(make_pair(0, 0, 10, 10, 20, 0, 10, 10));
    send_box_pair(make_pair(0, 0, 10, 10, 0, 30, 10, 10));
    send_box_pair(make_pair(0, 0, 100, 100, 25, 25, 50, 50));
    send_box_pair(make_pair(5, 5, 0, 10, 0, 0, 20, 20));
    send_box_pair(make_pair(1, 2, 0, 0, 300, 400, 7, 0));
    send_box_pair(make_pair(10, 10, 20, 20, 20, 20, 20, 20));
    send_box_pair(make_pair(0, 0, 2, 1, 1, 0, 2, 1));
    send_box_pair(make_pair(65535, 0, 0, 65535, 0, 65535, 65535, 0));
    send_box_pair(make_pair('hAAAA, 'h5555, 'hAAAA, 'h5555,
                            'h5555, 'hAAAA, 'h5555, 'hAAAA));
    send_box_pair(make_pair(0, 0, 1, 1, 0, 0, 65535, 65535));
  endtask

  // random pairs with idling on both sides
  task automatic test_random_pairs(input int count);
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    repeat (count) send_box_pair(random_box_pair());
  endtask

  // long output hold-off while the sender keeps offering, pipe fills and stalls
  task automatic test_output_holdoff(input int count);
    src_idle_on      = 1'b0;
    sink_idle_on     = 1'b0;
    sink_holdoff_req = 1'b1;
    repeat (count) send_box_pair(random_box_pair());
  endtask

  // back-to-back words with no idling anywhere
  task automatic test_full_rate(input int count);
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    repeat (count) send_box_pair(random_box_pair());
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_shapes();
    test_random_pairs(1300);
    test_output_holdoff(150);
    test_full_rate(500);
    in_tvalid <= 1'b0;
    while (expected_iou.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
